/* hw/rtl/swpl_pkg.sv */
// Shared constants and controller/datapath interface types for the packet limiter.
`default_nettype none
package swpl_pkg;

    // Sizing
    localparam int BUF_BYTES   = 65536;
    localparam int WIN_ENTRIES = 64;

    // Field widths
    localparam int CHUNK_W   = 17;
    localparam int TIME_W    = 63;
    localparam int PB_W      = 13;
    localparam int WLEN_W    = 36;
    localparam int SUM_W     = 24;
    localparam int REL_W     = 17;
    localparam int LEVEL_W   = $clog2(BUF_BYTES + 1);
    localparam int PTR_W     = $clog2(WIN_ENTRIES);
    localparam int CNT_W     = PTR_W + 1;
    localparam int DIV_W     = LEVEL_W;
    localparam int DIV_IDX_W = $clog2(DIV_W);
    localparam int REC_W     = TIME_W + LEVEL_W;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 36;
    localparam logic [CFG_IDX_W-1:0] CFG_PKT_SIZE          = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH_NS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_BYTE_LIMIT = 2'd2;

    localparam logic [PB_W-1:0]   PB_RESET   = 13'd64;
    localparam logic [WLEN_W-1:0] WLEN_RESET = 36'd1000000000;
    localparam logic [SUM_W-1:0]  LIMIT_RESET = 24'd16000;

    typedef struct packed {
        logic accept;    // take the request, add chunk to the buffer
        logic pop;       // expire the oldest record
        logic setup;     // load the divider
        logic div_step;  // one quotient bit
        logic commit;    // log the release and update totals
        logic emit;      // load the output register
    } cmd_t;

    typedef struct packed {
        logic ring_empty;
        logic expired;
        logic no_release;
        logic div_last;
        logic out_free;
    } status_t;

endpackage
`default_nettype wire

/* hw/rtl/swpl_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module swpl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

/* hw/rtl/swpl_ctrl.sv */
// Controller state machine: sequences accept, expiry, division, commit and output.
`default_nettype none
module swpl_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire swpl_pkg::status_t status,
    output swpl_pkg::cmd_t         cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EXPIRE = 3'd1;
    localparam logic [2:0] ST_SETUP  = 3'd2;
    localparam logic [2:0] ST_DIVIDE = 3'd3;
    localparam logic [2:0] ST_COMMIT = 3'd4;
    localparam logic [2:0] ST_EMIT   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_EXPIRE;
                end
            end
            ST_EXPIRE:
            begin
                if (status.ring_empty || !status.expired)
                begin
                    state_next = ST_SETUP;
                end
                else
                begin
                    cmd.pop = 1'b1;
                end
            end
            ST_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = status.no_release ? ST_COMMIT : ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                // hold until the previous result has been taken
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/swpl_dp.sv */
// Datapath: buffer level, window sum, record ring, serial divider and output register.
`default_nettype none
module swpl_dp (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [swpl_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  wire logic [swpl_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  wire logic [swpl_pkg::CHUNK_W-1:0]        chunk_bytes,
    input  wire logic [swpl_pkg::TIME_W-1:0]         now_time,
    input  wire swpl_pkg::cmd_t                      cmd,
    output swpl_pkg::status_t                        status,
    input  wire logic                                out_ready,
    output logic                                     out_valid,
    output logic [swpl_pkg::REL_W-1:0]               packets_released,
    output logic [swpl_pkg::LEVEL_W-1:0]             buffered_level,
    output logic [swpl_pkg::SUM_W-1:0]               window_total,
    output logic                                     chunk_dropped
);

    // Configuration
    logic [swpl_pkg::PB_W-1:0]   pkt_size_reg;
    logic [swpl_pkg::WLEN_W-1:0] window_length_reg;
    logic [swpl_pkg::SUM_W-1:0]  byte_limit_reg;

    // Persistent state
    logic [swpl_pkg::LEVEL_W-1:0] level_reg;
    logic [swpl_pkg::LEVEL_W-1:0] level_next;
    logic [swpl_pkg::SUM_W-1:0]   sum_reg;
    logic [swpl_pkg::SUM_W-1:0]   sum_next;
    logic [swpl_pkg::PTR_W-1:0]   head_reg;
    logic [swpl_pkg::PTR_W-1:0]   head_next;
    logic [swpl_pkg::CNT_W-1:0]   count_reg;
    logic [swpl_pkg::CNT_W-1:0]   count_next;

    // Per-request working registers
    logic [swpl_pkg::TIME_W-1:0]    now_reg;
    logic                           dropped_reg;
    logic [swpl_pkg::DIV_W-1:0]     dividend_reg;
    logic [swpl_pkg::DIV_IDX_W-1:0] bit_idx_reg;
    logic [swpl_pkg::PB_W-1:0]      rem_reg;
    logic [swpl_pkg::REL_W-1:0]     quot_reg;

    // Output register
    logic                          out_valid_reg;
    logic [swpl_pkg::REL_W-1:0]    out_rel_reg;
    logic [swpl_pkg::LEVEL_W-1:0]  out_level_reg;
    logic [swpl_pkg::SUM_W-1:0]    out_sum_reg;
    logic                          out_drop_reg;

    // Record ring
    logic                         ram_we;
    logic [swpl_pkg::PTR_W-1:0]   ram_waddr;
    logic [swpl_pkg::REC_W-1:0]   ram_wdata;
    logic [swpl_pkg::PTR_W-1:0]   ram_raddr;
    logic [swpl_pkg::REC_W-1:0]   ram_rdata;
    logic [swpl_pkg::TIME_W-1:0]  rec_time;
    logic [swpl_pkg::LEVEL_W-1:0] rec_size;

    logic [swpl_pkg::LEVEL_W:0]   level_add;
    logic [swpl_pkg::LEVEL_W-1:0] level_sat;
    logic [swpl_pkg::TIME_W:0]    age_diff;
    logic                         expired;
    logic [swpl_pkg::SUM_W-1:0]   rec_size_ext;
    logic [swpl_pkg::SUM_W-1:0]   room;
    logic [swpl_pkg::DIV_W-1:0]   div_in;
    logic [swpl_pkg::PB_W:0]      rem_shift;
    logic                         rem_ge;
    logic [swpl_pkg::LEVEL_W-1:0] rel_bytes;
    logic                         do_log;

    swpl_ram #(
        .WIDTH(swpl_pkg::REC_W),
        .DEPTH(swpl_pkg::WIN_ENTRIES)
    ) u_ring (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign rec_time = ram_rdata[swpl_pkg::REC_W-1:swpl_pkg::LEVEL_W];
    assign rec_size = ram_rdata[swpl_pkg::LEVEL_W-1:0];

    // The read port follows the head, so the oldest record is ready when expiry starts
    assign ram_raddr = head_next;

    // Add the chunk and saturate at buffer capacity
    assign level_add = {1'b0, level_reg} + (swpl_pkg::LEVEL_W + 1)'(chunk_bytes);
    assign level_sat = (level_add > (swpl_pkg::LEVEL_W + 1)'(swpl_pkg::BUF_BYTES))
                     ? swpl_pkg::LEVEL_W'(swpl_pkg::BUF_BYTES)
                     : level_add[swpl_pkg::LEVEL_W-1:0];

    // A record newer than now gives a negative age and never expires
    assign age_diff = {1'b0, now_reg} - {1'b0, rec_time};
    assign expired  = !age_diff[swpl_pkg::TIME_W] &&
                      (age_diff[swpl_pkg::TIME_W-1:0] >
                       swpl_pkg::TIME_W'(window_length_reg));
    assign rec_size_ext = swpl_pkg::SUM_W'(rec_size);

    // min(level, room) / packet size gives the packet count in one division
    assign room   = (byte_limit_reg > sum_reg) ? (byte_limit_reg - sum_reg) : '0;
    assign div_in = (room < swpl_pkg::SUM_W'(level_reg)) ? room[swpl_pkg::DIV_W-1:0]
                                                         : level_reg;

    assign rem_shift = {rem_reg, dividend_reg[bit_idx_reg]};
    assign rem_ge    = (rem_shift >= {1'b0, pkt_size_reg});

    // Released bytes are the dividend less the remainder
    assign rel_bytes = dividend_reg - swpl_pkg::LEVEL_W'(rem_reg);
    assign do_log    = cmd.commit && (quot_reg != '0);

    assign ram_we    = do_log;
    assign ram_waddr = head_reg + count_reg[swpl_pkg::PTR_W-1:0];
    assign ram_wdata = {now_reg, rel_bytes};

    assign status.ring_empty = (count_reg == '0);
    assign status.expired    = expired;
    assign status.no_release = (pkt_size_reg == '0) ||
                               (count_reg == swpl_pkg::CNT_W'(swpl_pkg::WIN_ENTRIES));
    assign status.div_last   = (bit_idx_reg == '0);
    assign status.out_free   = !out_valid_reg || out_ready;

    always_comb
    begin
        level_next = level_reg;
        sum_next   = sum_reg;
        head_next  = head_reg;
        count_next = count_reg;
        if (cmd.accept)
        begin
            level_next = level_sat;
        end
        if (cmd.pop)
        begin
            sum_next   = (sum_reg >= rec_size_ext) ? (sum_reg - rec_size_ext) : '0;
            head_next  = head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end
        if (do_log)
        begin
            sum_next   = sum_reg + swpl_pkg::SUM_W'(rel_bytes);
            level_next = level_reg - rel_bytes;
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pkt_size_reg      <= swpl_pkg::PB_RESET;
            window_length_reg <= swpl_pkg::WLEN_RESET;
            byte_limit_reg    <= swpl_pkg::LIMIT_RESET;
            level_reg         <= '0;
            sum_reg           <= '0;
            head_reg          <= '0;
            count_reg         <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    swpl_pkg::CFG_PKT_SIZE:
                        pkt_size_reg <= cfg_wdata[swpl_pkg::PB_W-1:0];
                    swpl_pkg::CFG_WINDOW_LENGTH_NS:
                        window_length_reg <= cfg_wdata[swpl_pkg::WLEN_W-1:0];
                    swpl_pkg::CFG_WINDOW_BYTE_LIMIT:
                        byte_limit_reg <= cfg_wdata[swpl_pkg::SUM_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            level_reg <= level_next;
            sum_reg   <= sum_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            now_reg     <= now_time;
            dropped_reg <= (level_add > (swpl_pkg::LEVEL_W + 1)'(swpl_pkg::BUF_BYTES));
        end
        if (cmd.setup)
        begin
            dividend_reg <= div_in;
            bit_idx_reg  <= swpl_pkg::DIV_IDX_W'(swpl_pkg::DIV_W - 1);
            rem_reg      <= '0;
            quot_reg     <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg     <= rem_ge ? swpl_pkg::PB_W'(rem_shift - {1'b0, pkt_size_reg})
                                  : rem_shift[swpl_pkg::PB_W-1:0];
            quot_reg    <= {quot_reg[swpl_pkg::REL_W-2:0], rem_ge};
            bit_idx_reg <= bit_idx_reg - 1'b1;
        end
        if (cmd.emit)
        begin
            out_rel_reg   <= quot_reg;
            out_level_reg <= level_reg;
            out_sum_reg   <= sum_reg;
            out_drop_reg  <= dropped_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign packets_released = out_rel_reg;
    assign buffered_level   = out_level_reg;
    assign window_total     = out_sum_reg;
    assign chunk_dropped    = out_drop_reg;

endmodule
`default_nettype wire

/* hw/rtl/sliding_window_packet_limiter.sv */
// Each request runs accept, expiry of E records (E = records expired, 0..64), divider
// setup, division, commit and emit; division is skipped when the packet size is zero
// or the ring is full. One request is handled at a time; the expiry walk pops
// one ring record per cycle and the packet count comes from a bit-serial divider.
// A new request is taken while the result waits; a stalled result holds the next one back.
// Reset (rst_n, async, active low) empties buffer, window sum and ring; ring data is kept.
`default_nettype none
module sliding_window_packet_limiter (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [swpl_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  wire logic [swpl_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [79:0]                     s_tdata,  // chunk_bytes[16:0], now_time[79:17]
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [63:0]                          m_tdata   // packets_released[16:0],
                                                           // buffered_level[33:17],
                                                           // window_total[57:34],
                                                           // chunk_dropped[58], zero[63:59]
);

    swpl_pkg::cmd_t    cmd;
    swpl_pkg::status_t status;

    logic [swpl_pkg::REL_W-1:0]   packets_released;
    logic [swpl_pkg::LEVEL_W-1:0] buffered_level;
    logic [swpl_pkg::SUM_W-1:0]   window_total;
    logic                         chunk_dropped;

    swpl_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(s_tvalid),
        .in_ready(s_tready),
        .status  (status),
        .cmd     (cmd)
    );

    swpl_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .chunk_bytes     (s_tdata[16:0]),
        .now_time        (s_tdata[79:17]),
        .cmd             (cmd),
        .status          (status),
        .out_ready       (m_tready),
        .out_valid       (m_tvalid),
        .packets_released(packets_released),
        .buffered_level  (buffered_level),
        .window_total    (window_total),
        .chunk_dropped   (chunk_dropped)
    );

    assign m_tdata = {5'b0, chunk_dropped, window_total, buffered_level, packets_released};

endmodule
`default_nettype wire

/* hw/rtl/swpl_checker.sv */
// Port-level checker for the packet limiter, bound to the top level.
`default_nettype none
module swpl_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [63:0] m_tdata
);

    // A stalled result holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // One request at a time: the input side closes right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while busy");

    // Buffer level never exceeds capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[33:17] <= 17'(swpl_pkg::BUF_BYTES))
        else $error("buffered level above capacity");

    // Padding above the result fields stays zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[63:59] == 5'b0)
        else $error("padding bits not zero");

endmodule

bind sliding_window_packet_limiter swpl_checker u_swpl_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
